[rtl/core/mhfs_pkg.sv]
// Package: types, constants and the CORDIC arctangent table for the heading supervisor.
`default_nettype none
package mhfs_pkg;

  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam int unsigned XY_W = 27;  // scaled sample plus CORDIC growth
  localparam int unsigned Z_W = 28;   // angle accumulator, 2^-24 rad units
  localparam int unsigned ATAN_IDX_W = 5;

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'd1;

  localparam logic [14:0] DEADBAND_RST = 15'd82;
  localparam logic [15:0] TIMEOUT_RST = 16'd1000;

  localparam logic signed [15:0] PI_Q13 = 16'sd25736;
  localparam logic signed [Z_W-1:0] HALF_PI_Q24 = 28'sd26353589;

  typedef struct packed {
    logic               first_read_ok;
    logic               retry_read_ok;
    logic signed [15:0] mag_x;
    logic signed [15:0] mag_y;
    logic        [31:0] now_ms;
  } mhfs_in_t;

  typedef struct packed {
    logic signed [15:0] heading;
    logic               healthy;
    logic               fault_active;
    logic        [31:0] fault_count;
  } mhfs_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROTATE,
    ST_COMMIT
  } mhfs_state_e;

  typedef struct packed {
    logic load;    // capture input transfer, pre-rotate
    logic step;    // one CORDIC iteration
    logic commit;  // update supervisor state
  } mhfs_cmd_t;

  typedef struct packed {
    logic read_ok;    // incoming item carries a good sample
    logic last_step;  // final CORDIC iteration in progress
  } mhfs_status_t;

  // atan(2^-i) in 2^-24 rad, rounded to nearest
  function automatic logic [23:0] atan_q24(input logic [ATAN_IDX_W-1:0] i);
    logic [23:0] a;
    case (i)
      5'd0:  a = 24'd13176795;
      5'd1:  a = 24'd7778716;
      5'd2:  a = 24'd4110060;
      5'd3:  a = 24'd2086331;
      5'd4:  a = 24'd1047214;
      5'd5:  a = 24'd524117;
      5'd6:  a = 24'd262123;
      5'd7:  a = 24'd131069;
      5'd8:  a = 24'd65536;
      5'd9:  a = 24'd32768;
      5'd10: a = 24'd16384;
      5'd11: a = 24'd8192;
      5'd12: a = 24'd4096;
      5'd13: a = 24'd2048;
      5'd14: a = 24'd1024;
      5'd15: a = 24'd512;
      5'd16: a = 24'd256;
      5'd17: a = 24'd128;
      5'd18: a = 24'd64;
      5'd19: a = 24'd32;
      5'd20: a = 24'd16;
      5'd21: a = 24'd8;
      5'd22: a = 24'd4;
      5'd23: a = 24'd2;
      default: a = 24'd0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

[rtl/core/magnetometer_heading_fault_supervisor.sv]
// Top level: magnetometer heading and fault supervisor.
//
//   port group   direction  flow control   content
//   in_*         input      valid/ready    read flags, mag x/y sample, timestamp
//   out_*        output     valid/ready    heading, healthy, fault flag, fault count
//   cfg_*        input      write enable   deadband, fault timeout
//
// A good read passes through capture, the CORDIC iterations (one CORDIC step per
// cycle in the shared iteration unit) and commit; a failed read skips the iterations.
// The supervisor state registers serve as the result register; a new item is
// taken while a result waits, and its commit holds until that result transfers.
// Reset returns config to 82 / 1000 and clears the control and supervisor state; no clearing pass.
`default_nettype none
module magnetometer_heading_fault_supervisor #(
  parameter int unsigned CORDIC_STEPS = mhfs_pkg::CORDIC_STEPS_DEF
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             in_valid_i,
  output logic                            in_ready_o,
  input  mhfs_pkg::mhfs_in_t              in_data_i,
  output logic                            out_valid_o,
  input  wire                             out_ready_i,
  output mhfs_pkg::mhfs_out_t             out_data_o,
  input  wire                             cfg_we_i,
  input  wire  [mhfs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire  [mhfs_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import mhfs_pkg::*;

  mhfs_cmd_t    cmd;
  mhfs_status_t status;

  mhfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mhfs_dp #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule
`default_nettype wire

[rtl/core/mhfs_ctrl.sv]
// Controller: sequences capture, CORDIC iterations, commit and the result handshake.
`default_nettype none
module mhfs_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  input  mhfs_pkg::mhfs_status_t status_i,
  output mhfs_pkg::mhfs_cmd_t  cmd_o
);
  import mhfs_pkg::*;

  mhfs_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.read_ok ? ST_ROTATE : ST_COMMIT;
        end
      end
      ST_ROTATE: begin
        cmd_o.step = 1'b1;
        if (status_i.last_step) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        // state regs double as the output register: wait until the old result is taken
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

[rtl/core/mhfs_dp.sv]
// Datapath: config registers, iterative CORDIC atan2, deadband and fault bookkeeping.
`default_nettype none
module mhfs_dp #(
  parameter int unsigned CORDIC_STEPS = mhfs_pkg::CORDIC_STEPS_DEF
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_we_i,
  input  wire  [mhfs_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire  [mhfs_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  mhfs_pkg::mhfs_in_t                  in_data_i,
  input  mhfs_pkg::mhfs_cmd_t                 cmd_i,
  output mhfs_pkg::mhfs_status_t              status_o,
  output mhfs_pkg::mhfs_out_t                 out_data_o
);
  import mhfs_pkg::*;

  localparam int unsigned CW = $clog2(CORDIC_STEPS);

  // configuration
  logic [14:0] deadband_q;
  logic [15:0] timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadband_q <= DEADBAND_RST;
      timeout_q  <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DEADBAND: deadband_q <= cfg_data_i[14:0];
        REG_TIMEOUT:  timeout_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // captured item
  logic        ok1_q, ok2_q, zero_q;
  logic [31:0] now_q;
  logic signed [XY_W-1:0] x_q, y_q;
  logic signed [Z_W-1:0]  z_q;
  logic [CW-1:0]          cnt_q;

  logic signed [XY_W-1:0] x0, y0, xs, ys, dx, dy;
  logic signed [Z_W-1:0]  z0, a;

  assign status_o.read_ok   = in_data_i.first_read_ok | in_data_i.retry_read_ok;
  assign status_o.last_step = (cnt_q == CW'(CORDIC_STEPS - 1));

  // quadrant pre-rotation into the right half plane
  always_comb begin
    xs = {{(XY_W-24){in_data_i.mag_x[15]}}, in_data_i.mag_x, 8'd0};
    ys = {{(XY_W-24){in_data_i.mag_y[15]}}, in_data_i.mag_y, 8'd0};
    x0 = xs;
    y0 = ys;
    z0 = '0;
    if (xs < 0) begin
      if (ys >= 0) begin
        x0 = ys;
        y0 = -xs;
        z0 = HALF_PI_Q24;
      end else begin
        x0 = -ys;
        y0 = xs;
        z0 = -HALF_PI_Q24;
      end
    end
  end

  assign dx = y_q >>> cnt_q;
  assign dy = x_q >>> cnt_q;
  assign a  = Z_W'(signed'({1'b0, atan_q24(ATAN_IDX_W'(cnt_q))}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load) begin
      cnt_q <= '0;
    end else if (cmd_i.step && !status_o.last_step) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ok1_q  <= in_data_i.first_read_ok;
      ok2_q  <= in_data_i.retry_read_ok;
      now_q  <= in_data_i.now_ms;
      zero_q <= (in_data_i.mag_x == 16'sd0) && (in_data_i.mag_y == 16'sd0);
      x_q    <= x0;
      y_q    <= y0;
      z_q    <= z0;
    end else if (cmd_i.step) begin
      if (y_q >= 0) begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + a;
      end else begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - a;
      end
    end
  end

  // round half up to Q3.13 and clamp
  logic signed [Z_W-1:0]  z_rnd;
  logic signed [Z_W-12:0] r;
  logic signed [15:0]     fresh;
  logic signed [16:0]     diff;
  logic        [16:0]     mag;
  logic                   big_change;

  assign z_rnd = z_q + Z_W'(1024);
  assign r     = z_rnd[Z_W-1:11];

  always_comb begin
    if (zero_q) begin
      fresh = '0;
    end else if (r > 17'(PI_Q13)) begin
      fresh = PI_Q13;
    end else if (r < -17'(PI_Q13)) begin
      fresh = -PI_Q13;
    end else begin
      fresh = r[15:0];
    end
  end

  assign diff       = 17'(fresh) - 17'(out_data_o.heading);
  assign mag        = diff[16] ? 17'(-diff) : 17'(diff);
  assign big_change = {mag, 1'b0} >= {3'd0, deadband_q};

  // supervisor state, also the result register
  logic signed [15:0] heading_q, heading_d;
  logic               healthy_q, healthy_d;
  logic               fault_q, fault_d;
  logic [31:0]        start_q, start_d;
  logic [31:0]        count_q, count_d;
  logic [31:0]        age;

  assign age = now_q - start_d;

  always_comb begin
    heading_d = heading_q;
    healthy_d = healthy_q;
    fault_d   = fault_q;
    start_d   = start_q;
    count_d   = count_q;
    if (!ok1_q && !fault_q) begin
      fault_d = 1'b1;
      start_d = now_q;
      count_d = count_q + 32'd1;
    end
    if (ok1_q || ok2_q) begin
      if (big_change) begin
        heading_d = fresh;
      end
      healthy_d = 1'b1;
      fault_d   = 1'b0;
      start_d   = now_q;
    end else begin
      healthy_d = age < {16'd0, timeout_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heading_q <= '0;
      healthy_q <= 1'b0;
      fault_q   <= 1'b0;
      start_q   <= '0;
      count_q   <= '0;
    end else if (cmd_i.commit) begin
      heading_q <= heading_d;
      healthy_q <= healthy_d;
      fault_q   <= fault_d;
      start_q   <= start_d;
      count_q   <= count_d;
    end
  end

  assign out_data_o.heading      = heading_q;
  assign out_data_o.healthy      = healthy_q;
  assign out_data_o.fault_active = fault_q;
  assign out_data_o.fault_count  = count_q;

endmodule
`default_nettype wire

[test/mhfs_checker.sv]
`timescale 1ns / 100ps
// Checker: predicts heading/fault results from accepted inputs and compares each output transfer.
module mhfs_checker #(
  parameter int unsigned CORDIC_STEPS = mhfs_pkg::CORDIC_STEPS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  mhfs_pkg::mhfs_in_t              in_data_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  mhfs_pkg::mhfs_out_t             out_data_i,
  input  logic                            cfg_we_i,
  input  logic [mhfs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mhfs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned                     err_count_o,
  output int unsigned                     pending_o
);
  import mhfs_pkg::*;

  // atan(2^-i) in 2^-24 rad
  localparam longint ATAN_LUT [24] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  logic [14:0]        deadband = DEADBAND_RST;
  logic [15:0]        timeout_ms = TIMEOUT_RST;
  logic signed [15:0] heading_q = '0;
  logic               healthy_q = 1'b0;
  logic               fault_q = 1'b0;
  logic [31:0]        fault_t0_ms = '0;
  logic [31:0]        episodes = '0;

  mhfs_out_t          expected_q[$];
  mhfs_out_t          want;
  mhfs_out_t          got;
  int unsigned        n_err = 0;

  assign err_count_o = n_err;
  assign pending_o = expected_q.size();

  function automatic logic signed [15:0] atan2_q13(input logic signed [15:0] xs,
                                                   input logic signed [15:0] ys);
    longint x, y, z, t, dx, dy, r;
    if (xs == 0 && ys == 0) return '0;
    x = longint'(xs) * 256;
    y = longint'(ys) * 256;
    z = 0;
    // swing into the right half plane first
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = longint'(HALF_PI_Q24);
      end else begin
        x = -y;
        y = t;
        z = -longint'(HALF_PI_Q24);
      end
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx;
        y -= dy;
        z += (i < 24) ? ATAN_LUT[i] : 0;
      end else begin
        x -= dx;
        y += dy;
        z -= (i < 24) ? ATAN_LUT[i] : 0;
      end
    end
    r = (z + 1024) >>> 11;
    if (r > longint'(PI_Q13)) r = longint'(PI_Q13);
    if (r < -longint'(PI_Q13)) r = -longint'(PI_Q13);
    return 16'(r);
  endfunction

  function automatic void absorb_sample(input mhfs_in_t it);
    logic signed [15:0] fresh;
    int                 delta;
    fresh = atan2_q13(it.mag_x, it.mag_y);
    delta = int'(fresh) - int'(heading_q);
    if (delta < 0) delta = -delta;
    if (2 * delta >= int'(deadband)) heading_q = fresh;
    healthy_q = 1'b1;
    fault_q = 1'b0;
    fault_t0_ms = it.now_ms;
  endfunction

  function automatic mhfs_out_t predict_update(input mhfs_in_t it);
    mhfs_out_t   res;
    logic [31:0] age;
    if (it.first_read_ok) begin
      absorb_sample(it);
    end else begin
      if (!fault_q) begin
        fault_q = 1'b1;
        fault_t0_ms = it.now_ms;
        episodes = episodes + 32'd1;
      end
      if (it.retry_read_ok) begin
        absorb_sample(it);
      end else begin
        age = it.now_ms - fault_t0_ms;
        healthy_q = age < 32'(timeout_ms);
      end
    end
    res.heading = heading_q;
    res.healthy = healthy_q;
    res.fault_active = fault_q;
    res.fault_count = episodes;
    return res;
  endfunction

  task automatic flag_error(input string what, input logic signed [63:0] exp_v,
                            input logic signed [63:0] got_v);
    n_err++;
    if (n_err <= 10)
      $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, exp_v, got_v);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadband = DEADBAND_RST;
      timeout_ms = TIMEOUT_RST;
      heading_q = '0;
      healthy_q = 1'b0;
      fault_q = 1'b0;
      fault_t0_ms = '0;
      episodes = '0;
      expected_q.delete();
    end else begin
      // output transfer is always for an older item than a same-edge input transfer
      if (out_valid_i && out_ready_i) begin
        got = out_data_i;
        if (expected_q.size() == 0) begin
          flag_error("unexpected result, heading", 'x, got.heading);
        end else begin
          want = expected_q.pop_front();
          if (got.heading !== want.heading)
            flag_error("heading", want.heading, got.heading);
          if (got.healthy !== want.healthy)
            flag_error("healthy", want.healthy, got.healthy);
          if (got.fault_active !== want.fault_active)
            flag_error("fault_active", want.fault_active, got.fault_active);
          if (got.fault_count !== want.fault_count)
            flag_error("fault_count", want.fault_count, got.fault_count);
        end
      end
      if (in_valid_i && in_ready_i) expected_q.push_back(predict_update(in_data_i));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_DEADBAND: deadband = cfg_data_i[14:0];
          REG_TIMEOUT:  timeout_ms = cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// Testbench top: stimulus, configuration phases, flow-control pressure and the verdict.
module tb;
  import mhfs_pkg::*;

  localparam int unsigned STEPS = CORDIC_STEPS_DEF;
  localparam int unsigned SETTLE = STEPS + 4;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASE_ITEMS = 220;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  mhfs_in_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  mhfs_out_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = REG_DEADBAND;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int unsigned           err_count;
  int unsigned           pending;
  int unsigned           cycles = 0;

  logic                  tx_idle = 1'b1;
  logic                  rx_idle = 1'b1;
  logic                  hold_req = 1'b0;

  logic [31:0]           clock_ms = '0;
  int unsigned           fail_left = 0;
  logic [15:0]           last_x = '0;
  logic [15:0]           last_y = '0;

  magnetometer_heading_fault_supervisor #(.CORDIC_STEPS(STEPS)) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  mhfs_checker #(.CORDIC_STEPS(STEPS)) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side: random stalls, or one long hold-off on request
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (rx_idle && $urandom_range(0, 99) < 29) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic mhfs_in_t pack_update(input bit first, input bit retry, input int x,
                                           input int y, input logic [31:0] now);
    mhfs_in_t it;
    it.first_read_ok = first;
    it.retry_read_ok = retry;
    it.mag_x = 16'(x);
    it.mag_y = 16'(y);
    it.now_ms = now;
    return it;
  endfunction

  function automatic logic [15:0] rand_axis(input logic [15:0] prev);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'($urandom_range(0, 8) - 4);
    if (r < 25) return prev + 16'($urandom_range(0, 64)) - 16'd32;  // deadband territory
    return 16'($urandom());
  endfunction

  // mostly good reads, plus fault episodes of random length that may end in a retry
  function automatic mhfs_in_t next_random();
    mhfs_in_t    it;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) clock_ms += $urandom_range(0, 200);
    else if (r < 90) clock_ms += $urandom_range(0, 70000);
    else clock_ms = $urandom();
    it.now_ms = clock_ms;
    last_x = rand_axis(last_x);
    last_y = rand_axis(last_y);
    it.mag_x = last_x;
    it.mag_y = last_y;
    if (fail_left == 0) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        it.first_read_ok = 1'b1;
        it.retry_read_ok = 1'($urandom_range(0, 1));
        return it;
      end
      if (r < 75) begin
        it.first_read_ok = 1'b0;
        it.retry_read_ok = 1'b1;
        return it;
      end
      fail_left = $urandom_range(1, 12);
    end
    fail_left--;
    it.first_read_ok = 1'b0;
    it.retry_read_ok = (fail_left == 0) ? 1'($urandom_range(0, 1)) : 1'b0;
    return it;
  endfunction

  // entered and left at a falling edge
  task automatic send(input mhfs_in_t it);
    if (tx_idle) begin
      while ($urandom_range(0, 99) < 29) begin
        in_valid <= 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    wait_results();
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: field extremes at reset config
    send(pack_update(1, 0, 0, 0, 32'd0));            // zero vector
    send(pack_update(1, 0, 32767, 0, 32'd10));
    send(pack_update(1, 0, -32768, 0, 32'd20));      // on the branch cut
    send(pack_update(1, 0, 0, 32767, 32'd30));
    send(pack_update(1, 0, 0, -32768, 32'd40));
    send(pack_update(1, 0, -32768, -32768, 32'd50));
    send(pack_update(1, 0, -32768, 32767, 32'd60));
    send(pack_update(1, 0, 32767, 32767, 32'd70));
    send(pack_update(1, 0, 32767, 32700, 32'd80));   // change below deadband
    send(pack_update(1, 0, -1, 0, 32'd90));
    send(pack_update(1, 0, -1, -1, 32'd100));
    send(pack_update(1, 1, 100, -200, 32'd110));     // retry flag ignored
    send(pack_update(0, 0, 5, 5, 32'hFFFF_FF00));    // new episode
    send(pack_update(0, 0, 5, 5, 32'hFFFF_FFFF));
    send(pack_update(0, 0, 5, 5, 32'h0000_0300));    // age across the wrap, over timeout
    send(pack_update(0, 1, -300, 700, 32'h0000_0400));
    send(pack_update(0, 1, 300, 700, 32'h0000_0500)); // counted and cleared at once
    send(pack_update(0, 0, 1, 1, 32'h0000_0600));
    send(pack_update(0, 0, 1, 1, 32'h0000_0600 + 32'd999));
    send(pack_update(0, 0, 1, 1, 32'h0000_0600 + 32'd1000));
    send(pack_update(1, 0, 5, -3, 32'hFFFF_FFFF));

    drain();
    write_reg(REG_DEADBAND, 16'h7FFF);               // beyond the angle range
    write_reg(REG_TIMEOUT, 16'd0);
    send(pack_update(0, 0, 0, 0, 32'd5));             // zero timeout: unhealthy at once
    send(pack_update(1, 0, -32768, 1, 32'd6));
    send(pack_update(0, 0, 9, 9, 32'd6));

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: begin
          write_reg(REG_DEADBAND, 16'(DEADBAND_RST));
          write_reg(REG_TIMEOUT, TIMEOUT_RST);
        end
        1: begin
          write_reg(REG_DEADBAND, 16'd0);
          write_reg(REG_TIMEOUT, 16'd0);
        end
        2: begin
          write_reg(REG_DEADBAND, 16'(PI_Q13));
          write_reg(REG_TIMEOUT, 16'hFFFF);
        end
        3: begin
          write_reg(REG_DEADBAND, 16'h7FFF);
          write_reg(REG_TIMEOUT, 16'd1);
        end
        4: begin
          write_reg(REG_DEADBAND, 16'($urandom_range(0, 400)));
          write_reg(REG_TIMEOUT, 16'($urandom_range(0, 3000)));
        end
        default: begin
          write_reg(REG_DEADBAND, 16'($urandom_range(0, 32767)));
          write_reg(REG_TIMEOUT, 16'($urandom()));
        end
      endcase
      tx_idle = (ph != 2);
      rx_idle = (ph != 2);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 3 && k == 10) hold_req = 1'b1;
        if (ph == 4 && k == PHASE_ITEMS / 2) wait_results();
        send(next_random());
      end
    end

    wait_results();
    repeat (SETTLE) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
